### rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 16;

  // Fixed field widths of the request and result ports
  localparam int REQ_W    = 3;
  localparam int TID_W    = 4;
  localparam int STATUS_W = 3;
  localparam int CUR_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_KILL    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SWITCH  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_BLOCKED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd6;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic start_scan;
    logic step_scan;
    logic commit;
  } rrts_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic scan_end;
    logic out_free;
  } rrts_status_t;

endpackage

### rtl/rrts_ctrl.sv
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  rrts_status_t dp_status,
  output rrts_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_status.need_scan && !dp_status.scan_done) begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end else if (dp_status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.step_scan = 1'b1;
        if (dp_status.scan_end) begin
          state_next = S_EXEC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/rrts_datapath.sv
module rrts_datapath
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rrts_cmd_t           cmd,
  output rrts_status_t        dp_status,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [TID_W-1:0]    thread_id,
  input  logic                is_initial,
  input  logic                has_context,
  input  logic                must_switch,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                switched,
  output logic                first_run,
  output logic [CUR_W-1:0]    current_thread,
  output logic [COUNT_W-1:0]  active_count,
  output logic                thread_valid
);

  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W  = $clog2(MAX_THREADS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_THREADS - 1);

  typedef logic [MAX_THREADS-1:0] mask_t;

  // Thread table
  mask_t             present, active, started, executed;
  logic [SLOT_W-1:0] cur;
  logic [CNT_W-1:0]  total;

  // Latched request
  logic [REQ_W-1:0] r_type;
  logic [TID_W-1:0] r_tid;
  logic             r_init, r_ctx, r_must;

  // Slot scanner
  logic [SLOT_W-1:0] ptr, target;
  logic [CNT_W-1:0]  scan_cnt;
  logic              scan_done, found;

  logic              in_range, is_kill, p_hit, a_hit, cur_exec;
  logic [SLOT_W-1:0] sidx;
  logic              scan_hit, scan_last;
  logic [CNT_W-1:0]  scan_limit;

  mask_t               present_next, active_next, started_next, executed_next;
  logic [SLOT_W-1:0]   cur_next;
  logic [CNT_W-1:0]    total_next;
  logic [STATUS_W-1:0] status_next;
  logic                switched_next, first_next;

  assign in_range = int'(r_tid) < MAX_THREADS;
  assign sidx     = SLOT_W'(r_tid);
  assign is_kill  = (r_type == REQ_KILL);
  assign p_hit    = in_range && present[sidx];
  assign a_hit    = in_range && active[sidx];
  assign cur_exec = executed[cur];

  // kill walks back over present slots, switch walks forward over active ones
  assign scan_hit   = is_kill ? present[ptr] : active[ptr];
  assign scan_limit = is_kill ? CNT_W'(MAX_THREADS - 1) : CNT_W'(MAX_THREADS);
  assign scan_last  = (scan_cnt == scan_limit);

  assign dp_status.need_scan =
      (is_kill && p_hit && (sidx == cur)) ||
      ((r_type == REQ_SWITCH) && (present != '0) &&
       ((total > CNT_W'(1)) || r_must) && !(!cur_exec && r_ctx));
  assign dp_status.scan_done = scan_done;
  assign dp_status.scan_end  = scan_hit || scan_last;
  assign dp_status.out_free  = !out_valid || !out_stall;

  always_comb begin
    present_next  = present;
    active_next   = active;
    started_next  = started;
    executed_next = executed;
    cur_next      = cur;
    total_next    = total;
    status_next   = ST_OK;
    switched_next = 1'b0;
    first_next    = 1'b0;
    if (!in_range && (r_type <= REQ_UNBLOCK)) begin
      status_next = ST_UNKNOWN;
    end else begin
      unique case (r_type)
        REQ_ADD: begin
          if (p_hit) begin
            status_next = ST_DUPLICATE;
          end else begin
            present_next[sidx]  = 1'b1;
            active_next[sidx]   = 1'b1;
            executed_next[sidx] = 1'b0;
            started_next[sidx]  = r_init;
            if (present == '0) begin
              cur_next = sidx;
            end
            total_next = total + 1'b1;
          end
        end
        REQ_KILL: begin
          if (!p_hit) begin
            status_next = ST_UNKNOWN;
          end else begin
            if ((sidx == cur) && found) begin
              cur_next = target;
            end
            // only an active thread was counted
            if (a_hit && (total != '0)) begin
              total_next = total - 1'b1;
            end
            present_next[sidx]  = 1'b0;
            active_next[sidx]   = 1'b0;
            started_next[sidx]  = 1'b0;
            executed_next[sidx] = 1'b0;
          end
        end
        REQ_BLOCK: begin
          if (!p_hit) begin
            status_next = ST_UNKNOWN;
          end else if (!a_hit) begin
            status_next = ST_BLOCKED;
          end else begin
            active_next[sidx] = 1'b0;
            if (total != '0) begin
              total_next = total - 1'b1;
            end
            if (total_next == '0) begin
              status_next = ST_DEADLOCK;
            end
          end
        end
        REQ_UNBLOCK: begin
          if (!p_hit) begin
            status_next = ST_UNKNOWN;
          end else if (a_hit) begin
            status_next = ST_NOT_BLOCKED;
          end else begin
            active_next[sidx] = 1'b1;
            total_next        = total + 1'b1;
          end
        end
        REQ_SWITCH: begin
          if (present == '0) begin
            status_next = ST_EMPTY;
          end else if ((total > CNT_W'(1)) || r_must) begin
            if (!cur_exec && r_ctx) begin
              // skip once: mark and stay
              executed_next[cur] = 1'b1;
            end else if (!found) begin
              status_next = ST_EMPTY;
            end else begin
              executed_next[cur]   = 1'b0;
              cur_next             = target;
              switched_next        = 1'b1;
              first_next           = !started[target];
              started_next[target] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type <= req_type;
      r_tid  <= thread_id;
      r_init <= is_initial;
      r_ctx  <= has_context;
      r_must <= must_switch;
    end
    if (cmd.start_scan) begin
      scan_cnt <= CNT_W'(1);
      if (is_kill) begin
        ptr <= (cur == '0) ? LAST_SLOT : cur - 1'b1;
      end else begin
        ptr <= (cur == LAST_SLOT) ? '0 : cur + 1'b1;
      end
    end else if (cmd.step_scan) begin
      if (scan_hit || scan_last) begin
        target <= ptr;
      end else begin
        scan_cnt <= scan_cnt + 1'b1;
        if (is_kill) begin
          ptr <= (ptr == '0) ? LAST_SLOT : ptr - 1'b1;
        end else begin
          ptr <= (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
        end
      end
    end
    if (cmd.commit) begin
      status         <= status_next;
      switched       <= switched_next;
      first_run      <= first_next;
      current_thread <= CUR_W'(cur_next);
      active_count   <= COUNT_W'(total_next);
      thread_valid   <= in_range && present_next[sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      active    <= '0;
      started   <= '0;
      executed  <= '0;
      cur       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      scan_done <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_done <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.step_scan && (scan_hit || scan_last)) begin
        scan_done <= 1'b1;
        found     <= scan_hit;
      end
      if (cmd.commit) begin
        present   <= present_next;
        active    <= active_next;
        started   <= started_next;
        executed  <= executed_next;
        cur       <= cur_next;
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/round_robin_thread_scheduler.sv
// Round-robin hardware thread table.
// Request channel: in_valid / in_stall carry req_type, thread_id, is_initial,
// has_context and must_switch. A request is taken on a clock edge with
// in_valid high and in_stall low. Every request gives exactly one result on
// the out_valid / out_stall channel (status, switched, first_run,
// current_thread, active_count, thread_valid), in request order.
// Add, block, unblock, a kill of a non-current slot and a switch that does
// not search need only the accept edge and the commit edge; the result is
// valid from the commit edge on. A kill of the current slot or a switch that
// searches first runs a slot scanner one slot per cycle; the scan stops at
// the first present (kill) or active (switch) slot.
// One request is in work at a time; in_stall stays high from accept to
// commit. The result register holds while out_stall is high; a request may
// be accepted meanwhile, but its commit waits until the result is taken.
// Synchronous reset empties the table, sets current slot and count to zero
// and drops out_valid.
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [TID_W-1:0]    thread_id,
  input  logic                is_initial,
  input  logic                has_context,
  input  logic                must_switch,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                switched,
  output logic                first_run,
  output logic [CUR_W-1:0]    current_thread,
  output logic [COUNT_W-1:0]  active_count,
  output logic                thread_valid
);

  rrts_cmd_t    cmd;
  rrts_status_t dp_status;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  rrts_datapath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .dp_status      (dp_status),
    .req_type       (req_type),
    .thread_id      (thread_id),
    .is_initial     (is_initial),
    .has_context    (has_context),
    .must_switch    (must_switch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .switched       (switched),
    .first_run      (first_run),
    .current_thread (current_thread),
    .active_count   (active_count),
    .thread_valid   (thread_valid)
  );

endmodule

### test/tb_round_robin_thread_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 700;
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = MAX_THREADS_DEF + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [TID_W-1:0] tid;
    logic             init;
    logic             ctx;
    logic             must;
  } sched_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                switched;
    logic                first_run;
    logic [CUR_W-1:0]    cur;
    logic [COUNT_W-1:0]  cnt;
    logic                tv;
  } sched_result_t;

  typedef struct packed {
    sched_req_t    rq;
    logic          typed;
    sched_result_t res;
  } dir_row_t;

  localparam sched_result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] req_type = '0;
  logic [TID_W-1:0] thread_id = '0;
  logic is_initial = 1'b0;
  logic has_context = 1'b0;
  logic must_switch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic switched;
  logic first_run;
  logic [CUR_W-1:0] current_thread;
  logic [COUNT_W-1:0] active_count;
  logic thread_valid;

  // predicted thread table
  logic [MAX_THREADS_DEF-1:0] slot_present = '0;
  logic [MAX_THREADS_DEF-1:0] slot_active = '0;
  logic [MAX_THREADS_DEF-1:0] slot_started = '0;
  logic [MAX_THREADS_DEF-1:0] slot_executed = '0;
  logic [CUR_W-1:0] cur_slot = '0;
  logic [COUNT_W-1:0] active_cnt = '0;

  sched_result_t pending_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int switch_cnt = 0;
  int first_run_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  logic no_idle = 1'b0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_EMPTY, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0}},
    '{'{REQ_KILL, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_UNKNOWN, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0}},
    '{'{REQ_BLOCK, 4'd3, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_UNKNOWN, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0}},
    '{'{REQ_UNBLOCK, 4'd3, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{ST_UNKNOWN, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0}},
    '{'{REQ_ADD, 4'd0, 1'b1, 1'b0, 1'b0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1}},
    '{'{REQ_ADD, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DUPLICATE, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1}},
    // single active thread, no force: nothing happens
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1}},
    // context on a fresh slot only marks it executed
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b1, '{ST_OK, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1}},
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_ADD, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 4'd0, 5'd2, 1'b1}},
    '{'{REQ_UNBLOCK, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{ST_NOT_BLOCKED, 1'b0, 1'b0, 4'd0, 5'd2, 1'b1}},
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_BLOCK, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_BLOCK, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_BLOCKED, 1'b0, 1'b0, 4'd0, 5'd1, 1'b1}},
    '{'{REQ_BLOCK, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{ST_DEADLOCK, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1}},
    // forced switch with nothing runnable
    '{'{REQ_SWITCH, 4'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_ADD, 4'd7, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    // kill of a blocked current slot walks back to the previous present one
    '{'{REQ_KILL, 4'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_KILL, 4'd15, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    // forced switch finds the current slot itself
    '{'{REQ_SWITCH, 4'd7, 1'b0, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_KILL, 4'd7, 1'b0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{REQ_UNUSED_LO, 4'd5, 1'b1, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{REQ_UNUSED_HI, 4'd10, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RES}
  };

  round_robin_thread_scheduler DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .thread_id      (thread_id),
    .is_initial     (is_initial),
    .has_context    (has_context),
    .must_switch    (must_switch),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .switched       (switched),
    .first_run      (first_run),
    .current_thread (current_thread),
    .active_count   (active_count),
    .thread_valid   (thread_valid)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the predicted table and return the expected result.
  task automatic schedule_step(input sched_req_t rq, output sched_result_t res);
    logic [CUR_W-1:0] start;
    logic [CUR_W-1:0] s;
    logic found;
    res = '0;
    start = cur_slot;
    found = 1'b0;
    unique case (rq.req)
      REQ_ADD: begin
        if (slot_present[rq.tid]) begin
          res.status = ST_DUPLICATE;
        end else begin
          slot_present[rq.tid] = 1'b1;
          slot_active[rq.tid] = 1'b1;
          slot_executed[rq.tid] = 1'b0;
          slot_started[rq.tid] = rq.init;
          if ($countones(slot_present) == 1) cur_slot = rq.tid;
          active_cnt = active_cnt + 1'b1;
        end
      end
      REQ_KILL: begin
        if (!slot_present[rq.tid]) begin
          res.status = ST_UNKNOWN;
        end else begin
          if (rq.tid == cur_slot) begin
            for (int k = 1; k < MAX_THREADS_DEF; k++) begin
              s = start - CUR_W'(k);
              if (!found && slot_present[s]) begin
                cur_slot = s;
                found = 1'b1;
              end
            end
          end
          // a blocked thread was already taken out of the count
          if (slot_active[rq.tid] && active_cnt != 0) active_cnt = active_cnt - 1'b1;
          slot_present[rq.tid] = 1'b0;
          slot_active[rq.tid] = 1'b0;
          slot_started[rq.tid] = 1'b0;
          slot_executed[rq.tid] = 1'b0;
        end
      end
      REQ_BLOCK: begin
        if (!slot_present[rq.tid]) begin
          res.status = ST_UNKNOWN;
        end else if (!slot_active[rq.tid]) begin
          res.status = ST_BLOCKED;
        end else begin
          slot_active[rq.tid] = 1'b0;
          if (active_cnt != 0) active_cnt = active_cnt - 1'b1;
          if (active_cnt == 0) res.status = ST_DEADLOCK;
        end
      end
      REQ_UNBLOCK: begin
        if (!slot_present[rq.tid]) begin
          res.status = ST_UNKNOWN;
        end else if (slot_active[rq.tid]) begin
          res.status = ST_NOT_BLOCKED;
        end else begin
          slot_active[rq.tid] = 1'b1;
          active_cnt = active_cnt + 1'b1;
        end
      end
      REQ_SWITCH: begin
        if (slot_present == 0) begin
          res.status = ST_EMPTY;
        end else if (active_cnt > 1 || rq.must) begin
          if (!slot_executed[start] && rq.ctx) begin
            slot_executed[start] = 1'b1;
          end else begin
            // scan after current, wrapping around to current itself
            for (int k = 1; k <= MAX_THREADS_DEF; k++) begin
              s = start + CUR_W'(k);
              if (!found && slot_active[s]) begin
                cur_slot = s;
                found = 1'b1;
              end
            end
            if (!found) begin
              res.status = ST_EMPTY;
            end else begin
              slot_executed[start] = 1'b0;
              res.switched = 1'b1;
              res.first_run = !slot_started[cur_slot];
              slot_started[cur_slot] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.cur = cur_slot;
    res.cnt = active_cnt;
    res.tv = slot_present[rq.tid];
  endtask

  function automatic logic [TID_W-1:0] pick_slot(logic [MAX_THREADS_DEF-1:0] m);
    logic [TID_W-1:0] s;
    s = TID_W'($urandom_range(MAX_THREADS_DEF - 1));
    if (m != 0)
      while (!m[s]) s = TID_W'($urandom_range(MAX_THREADS_DEF - 1));
    return s;
  endfunction

  // Mostly targeted requests on slots in the right state, some noise.
  task automatic next_request(output sched_req_t rq);
    int pick;
    pick = $urandom_range(99);
    rq.tid = TID_W'($urandom_range(MAX_THREADS_DEF - 1));
    rq.init = 1'($urandom_range(1));
    rq.ctx = 1'($urandom_range(1));
    rq.must = 1'($urandom_range(1));
    if (pick < 20) begin
      rq.req = REQ_ADD;
    end else if (pick < 33) begin
      rq.req = REQ_KILL;
      if ($urandom_range(9) != 0) rq.tid = pick_slot(slot_present);
    end else if (pick < 46) begin
      rq.req = REQ_BLOCK;
      if ($urandom_range(9) != 0) rq.tid = pick_slot(slot_active);
    end else if (pick < 59) begin
      rq.req = REQ_UNBLOCK;
      if ($urandom_range(9) != 0) rq.tid = pick_slot(slot_present & ~slot_active);
    end else if (pick < 96) begin
      rq.req = REQ_SWITCH;
    end else begin
      rq.req = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    end
  endtask

  task automatic send_request(input sched_req_t rq, input logic typed,
                              input sched_result_t typed_res);
    sched_result_t res;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    req_type <= rq.req;
    thread_id <= rq.tid;
    is_initial <= rq.init;
    has_context <= rq.ctx;
    must_switch <= rq.must;
    do @(posedge clk); while (in_stall);
    schedule_step(rq, res);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  initial begin
    sched_req_t rq;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) no_idle <= 1'b1;
      if (i == 420) no_idle <= 1'b0;
      if (i == 520) hold_request <= 1'b1;
      next_request(rq);
      send_request(rq, 1'b0, NO_RES);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d directed); checked %0d results, %0d switches, %0d first runs",
             NUM_DIRECTED + NUM_RANDOM, NUM_DIRECTED, results_seen, switch_cnt, first_run_cnt);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // result side: check, random stalls, and one long hold-off
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        results_seen++;
        if (exp_res.switched) switch_cnt++;
        if (exp_res.first_run) first_run_cnt++;
        check_field("status", int'(exp_res.status), int'(status));
        check_field("switched", int'(exp_res.switched), int'(switched));
        check_field("first_run", int'(exp_res.first_run), int'(first_run));
        check_field("current_thread", int'(exp_res.cur), int'(current_thread));
        check_field("active_count", int'(exp_res.cnt), int'(active_count));
        check_field("thread_valid", int'(exp_res.tv), int'(thread_valid));
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

### round_robin_thread_scheduler.f
rtl/rrts_pkg.sv
rtl/rrts_ctrl.sv
rtl/rrts_datapath.sv
rtl/round_robin_thread_scheduler.sv
test/tb_round_robin_thread_scheduler.sv
